/* rtl/core/assert_macros.svh */
// assertion macros used by the port level checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define TMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// same, with a caller supplied message
`define TMQ_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

`endif

/* rtl/core/tmq_pkg.sv */
// types and fixed widths for the trs matrix composer
// no dependencies; used by the top level, the scaling lane, the checkers and the testbench
package tmq_pkg;

  localparam int QW    = 32;         // q16.16 word
  localparam int PW    = 48;         // quaternion product after the shift
  localparam int RW    = 51;         // unsaturated rotation entry
  localparam int PL_W  = 33 + QW;    // low partial product
  localparam int PH_W  = RW;         // high partial product
  localparam int SUM_W = RW + QW;    // exact entry times scale
  localparam int SH_W  = SUM_W - 16; // after the fraction shift
  localparam int Q_ONE = 65536;
  localparam int N_ENT = 9;
  localparam int N_STG = 5;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] qp_t;
  typedef logic signed [RW-1:0] rot_t;

  // stage enables of the scaling lanes
  typedef struct packed {
    logic s_mul;
    logic s_sum;
    logic s_out;
  } stage_en_t;

endpackage

/* rtl/core/trs_matrix_from_quaternion.sv */
// trs matrix composer: one transaction per cycle while the result is not stalled;
// each stage holds a multiplier layer, a wide add or the saturation, and stages
// with a bubble keep filling during a stall.
// reset clears the stage valid bits only, the pipeline comes up empty.
// depends on tmq_pkg and tmq_scale_lane
module trs_matrix_from_quaternion
  import tmq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  q_t   pos_x_i,
  input  q_t   pos_y_i,
  input  q_t   pos_z_i,
  input  q_t   quat_w_i,
  input  q_t   quat_x_i,
  input  q_t   quat_y_i,
  input  q_t   quat_z_i,
  input  q_t   scale_x_i,
  input  q_t   scale_y_i,
  input  q_t   scale_z_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output q_t   e00_o,
  output q_t   e01_o,
  output q_t   e02_o,
  output q_t   e10_o,
  output q_t   e11_o,
  output q_t   e12_o,
  output q_t   e20_o,
  output q_t   e21_o,
  output q_t   e22_o,
  output q_t   t_x_o,
  output q_t   t_y_o,
  output q_t   t_z_o
);

  // product slots
  localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, WX = 6, WY = 7, WZ = 8;

  function automatic qp_t qprod(input q_t a, input q_t b);
    logic signed [2*QW-1:0] f;
    f = a * b;
    return f[2*QW-1:16];
  endfunction

  function automatic rot_t rot_diag(input qp_t a, input qp_t b);
    return rot_t'(Q_ONE) - ((rot_t'(a) + rot_t'(b)) <<< 1);
  endfunction

  function automatic rot_t rot_off(input qp_t a, input qp_t b, input logic sub);
    rot_t s;
    s = sub ? (rot_t'(a) - rot_t'(b)) : (rot_t'(a) + rot_t'(b));
    return s <<< 1;
  endfunction

  logic [N_STG-1:0] v_q;
  logic [N_STG:0]   en;
  stage_en_t        lane_en;

  qp_t  prod_q  [N_ENT];
  rot_t rot_q   [N_ENT];
  q_t   scl1_q  [3];
  q_t   scl2_q  [3];
  q_t   pos_q   [N_STG][3];
  q_t   ent     [N_ENT];

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[N_STG] = out_ready_i;
    for (int k = N_STG - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o    = en[0];
  assign out_valid_o   = v_q[N_STG-1];
  assign lane_en.s_mul = en[2];
  assign lane_en.s_sum = en[3];
  assign lane_en.s_out = en[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: quaternion products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q[XX] <= qprod(quat_x_i, quat_x_i);
      prod_q[YY] <= qprod(quat_y_i, quat_y_i);
      prod_q[ZZ] <= qprod(quat_z_i, quat_z_i);
      prod_q[XY] <= qprod(quat_x_i, quat_y_i);
      prod_q[XZ] <= qprod(quat_x_i, quat_z_i);
      prod_q[YZ] <= qprod(quat_y_i, quat_z_i);
      prod_q[WX] <= qprod(quat_w_i, quat_x_i);
      prod_q[WY] <= qprod(quat_w_i, quat_y_i);
      prod_q[WZ] <= qprod(quat_w_i, quat_z_i);
      scl1_q[0]  <= scale_x_i;
      scl1_q[1]  <= scale_y_i;
      scl1_q[2]  <= scale_z_i;
    end
  end

  // stage 1: rotation entries at full width
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rot_q[0] <= rot_diag(prod_q[YY], prod_q[ZZ]);
      rot_q[1] <= rot_off(prod_q[XY], prod_q[WZ], 1'b1);
      rot_q[2] <= rot_off(prod_q[XZ], prod_q[WY], 1'b0);
      rot_q[3] <= rot_off(prod_q[XY], prod_q[WZ], 1'b0);
      rot_q[4] <= rot_diag(prod_q[XX], prod_q[ZZ]);
      rot_q[5] <= rot_off(prod_q[YZ], prod_q[WX], 1'b1);
      rot_q[6] <= rot_off(prod_q[XZ], prod_q[WY], 1'b1);
      rot_q[7] <= rot_off(prod_q[YZ], prod_q[WX], 1'b0);
      rot_q[8] <= rot_diag(prod_q[XX], prod_q[YY]);
      scl2_q   <= scl1_q;
    end
  end

  // translation rides along with the lanes
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pos_q[0][0] <= pos_x_i;
      pos_q[0][1] <= pos_y_i;
      pos_q[0][2] <= pos_z_i;
    end
    for (int k = 1; k < N_STG; k++) begin
      if (en[k]) begin
        pos_q[k] <= pos_q[k-1];
      end
    end
  end

  // stages 2 to 4: scaling and saturation
  for (genvar i = 0; i < N_ENT; i++) begin : g_lane
    tmq_scale_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .rot_i   (rot_q[i]),
      .scale_i (scl2_q[i/3]),
      .ent_o   (ent[i])
    );
  end

  assign e00_o = ent[0];
  assign e01_o = ent[1];
  assign e02_o = ent[2];
  assign e10_o = ent[3];
  assign e11_o = ent[4];
  assign e12_o = ent[5];
  assign e20_o = ent[6];
  assign e21_o = ent[7];
  assign e22_o = ent[8];
  assign t_x_o = pos_q[N_STG-1][0];
  assign t_y_o = pos_q[N_STG-1][1];
  assign t_z_o = pos_q[N_STG-1][2];

endmodule

/* rtl/core/tmq_scale_lane.sv */
// one scaled rotation entry: split multiply, sum and shift, saturate
// depends on tmq_pkg
module tmq_scale_lane
  import tmq_pkg::*;
(
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  rot_t      rot_i,
  input  q_t        scale_i,
  output q_t        ent_o
);

  logic signed [PH_W-1:0] ph_q;
  logic signed [PL_W-1:0] pl_q;
  logic [SUM_W-1:0]       sum_d;
  logic [SH_W-1:0]        sh_q;
  logic                   fits_d;
  q_t                     ent_d;
  q_t                     ent_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s_mul) begin
      ph_q <= $signed(rot_i[RW-1:QW]) * scale_i;
      pl_q <= $signed({1'b0, rot_i[QW-1:0]}) * scale_i;
    end
  end

  // high part weighs 2^32, low part is sign extended
  assign sum_d = {ph_q, {QW{1'b0}}} + {{(SUM_W-PL_W){pl_q[PL_W-1]}}, pl_q};

  always_ff @(posedge clk_i) begin
    if (en_i.s_sum) begin
      sh_q <= sum_d[SUM_W-1:16];
    end
  end

  // fits when all bits above the word agree with its sign
  assign fits_d = (&sh_q[SH_W-1:QW-1]) | ~(|sh_q[SH_W-1:QW-1]);

  always_comb begin
    if (fits_d) begin
      ent_d = sh_q[QW-1:0];
    end else if (sh_q[SH_W-1]) begin
      ent_d = {1'b1, {(QW-1){1'b0}}};
    end else begin
      ent_d = {1'b0, {(QW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s_out) begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

/* rtl/core/tmq_checker.sv */
// port level checks for the trs matrix composer, bound to the top level
// depends on tmq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tmq_checker
  import tmq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input q_t   e00_o,
  input q_t   t_x_o
);

  // backpressure only comes from a stalled result
  `TMQ_ASSERT(a_stall_src, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i))

  // a taking sink never blocks the input side
  `TMQ_ASSERT_MSG(a_ready_pass, clk_i, rst_ni, out_ready_i |-> in_ready_o, "input blocked")

  `TMQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)

  `TMQ_ASSERT(a_out_stable, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> ($stable(e00_o) && $stable(t_x_o)))

endmodule

bind trs_matrix_from_quaternion tmq_checker u_tmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .e00_o       (e00_o),
  .t_x_o       (t_x_o)
);

/* tb/trs_compose_checker.sv */
// checker for the trs matrix composer: watches both channels, predicts each scaled
// rotation matrix and translation row, and compares results in order
// depends on tmq_pkg for the q16.16 word type and the fixed-point one
module trs_compose_checker
  import tmq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  q_t   pos_x_i,
  input  q_t   pos_y_i,
  input  q_t   pos_z_i,
  input  q_t   quat_w_i,
  input  q_t   quat_x_i,
  input  q_t   quat_y_i,
  input  q_t   quat_z_i,
  input  q_t   scale_x_i,
  input  q_t   scale_y_i,
  input  q_t   scale_z_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  q_t   e00_i,
  input  q_t   e01_i,
  input  q_t   e02_i,
  input  q_t   e10_i,
  input  q_t   e11_i,
  input  q_t   e12_i,
  input  q_t   e20_i,
  input  q_t   e21_i,
  input  q_t   e22_i,
  input  q_t   t_x_i,
  input  q_t   t_y_i,
  input  q_t   t_z_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int N_FIELDS = 12;
  localparam logic signed [95:0] SAT_HI = 96'sd2147483647;
  localparam logic signed [95:0] SAT_LO = -96'sd2147483648;

  // nine scaled entries row-major, then the translation row
  typedef struct {
    q_t f [N_FIELDS];
  } trs_matrix_t;

  trs_matrix_t expected_matrices [$];
  string       field_names [N_FIELDS] = '{"e00", "e01", "e02", "e10", "e11", "e12",
                                          "e20", "e21", "e22", "t_x", "t_y", "t_z"};

  assign pending_o = expected_matrices.size();

  // product of two q16.16 words, floored, kept at full width
  function automatic longint quat_mul(input q_t a, input q_t b);
    return (longint'(a) * longint'(b)) >>> 16;
  endfunction

  // exact entry times scale, floored by the fraction shift, then saturated
  function automatic q_t scale_entry(input longint rot, input q_t s);
    logic signed [95:0] rw;
    logic signed [95:0] sw;
    logic signed [95:0] sh;
    rw = rot;
    sw = s;
    sh = (rw * sw) >>> 16;
    if (sh > SAT_HI) return q_t'(32'h7fff_ffff);
    if (sh < SAT_LO) return q_t'(32'h8000_0000);
    return q_t'(sh[31:0]);
  endfunction

  function automatic trs_matrix_t compose_trs_matrix(
    input q_t px, input q_t py, input q_t pz,
    input q_t w, input q_t x, input q_t y, input q_t z,
    input q_t sx, input q_t sy, input q_t sz
  );
    longint      xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint      one;
    longint      rot [9];
    trs_matrix_t m;
    one = longint'(Q_ONE);
    xx = quat_mul(x, x);
    yy = quat_mul(y, y);
    zz = quat_mul(z, z);
    xy = quat_mul(x, y);
    xz = quat_mul(x, z);
    yz = quat_mul(y, z);
    wx = quat_mul(w, x);
    wy = quat_mul(w, y);
    wz = quat_mul(w, z);
    rot[0] = one - 2 * (yy + zz);
    rot[1] = 2 * (xy - wz);
    rot[2] = 2 * (xz + wy);
    rot[3] = 2 * (xy + wz);
    rot[4] = one - 2 * (xx + zz);
    rot[5] = 2 * (yz - wx);
    rot[6] = 2 * (xz - wy);
    rot[7] = 2 * (yz + wx);
    rot[8] = one - 2 * (xx + yy);
    for (int c = 0; c < 3; c++) begin
      m.f[c]     = scale_entry(rot[c], sx);
      m.f[3 + c] = scale_entry(rot[3 + c], sy);
      m.f[6 + c] = scale_entry(rot[6 + c], sz);
    end
    m.f[9]  = px;
    m.f[10] = py;
    m.f[11] = pz;
    return m;
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    trs_matrix_t exp_m;
    q_t          got [N_FIELDS];
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_matrices.push_back(compose_trs_matrix(
          pos_x_i, pos_y_i, pos_z_i, quat_w_i, quat_x_i, quat_y_i, quat_z_i,
          scale_x_i, scale_y_i, scale_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{e00_i, e01_i, e02_i, e10_i, e11_i, e12_i,
                e20_i, e21_i, e22_i, t_x_i, t_y_i, t_z_i};
        if (expected_matrices.size() == 0) begin
          $error("result transaction with no matrix expected");
          fail_count_o++;
        end else begin
          exp_m = expected_matrices.pop_front();
          for (int k = 0; k < N_FIELDS; k++) begin
            if (got[k] !== exp_m.f[k]) begin
              $error("%s mismatch: expected %0d, got %0d", field_names[k], exp_m.f[k], got[k]);
              fail_count_o++;
            end
          end
        end
      end
    end
  end

endmodule

/* tb/trs_matrix_from_quaternion_tb.sv */
// testbench top for the trs matrix composer: clock, reset, transform stimulus
// with idle and stall phases, and the verdict
// depends on tmq_pkg, trs_matrix_from_quaternion and trs_compose_checker
module trs_matrix_from_quaternion_tb;
  import tmq_pkg::*;

  localparam int N_RANDOM   = 400;     // per random phase
  localparam int LONG_HOLD  = 200;
  localparam int MAX_CYCLES = 300000;

  // stimulus word order: pos x y z, quat w x y z, scale x y z
  typedef q_t xform_t [10];

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  q_t   pos_x_i, pos_y_i, pos_z_i;
  q_t   quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  q_t   scale_x_i, scale_y_i, scale_z_i;
  logic out_valid_o;
  logic out_ready_i;
  q_t   e00_o, e01_o, e02_o, e10_o, e11_o, e12_o, e20_o, e21_o, e22_o;
  q_t   t_x_o, t_y_o, t_z_o;

  int fail_count;
  int pending;
  int in_idle_pct;
  int out_stall_pct;
  int hold_off_reqs;
  int cycle_count;

  trs_matrix_from_quaternion dut (.*);

  trs_compose_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .quat_w_i     (quat_w_i),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .scale_x_i    (scale_x_i),
    .scale_y_i    (scale_y_i),
    .scale_z_i    (scale_z_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .e00_i        (e00_o),
    .e01_i        (e01_o),
    .e02_i        (e02_o),
    .e10_i        (e10_o),
    .e11_i        (e11_o),
    .e12_i        (e12_o),
    .e20_i        (e20_o),
    .e21_i        (e21_o),
    .e22_i        (e22_o),
    .t_x_i        (t_x_o),
    .t_y_i        (t_y_o),
    .t_z_i        (t_z_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_off_done;
    hold_off_done = 0;
    out_ready_i   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_done != hold_off_reqs) begin
        hold_off_done++;
        out_ready_i = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        out_ready_i = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  function automatic q_t pick_corner();
    case ($urandom_range(6))
      0:       return q_t'(0);
      1:       return q_t'(1);
      2:       return q_t'(-1);
      3:       return q_t'(32'h7fff_ffff);
      4:       return q_t'(32'h8000_0000);
      5:       return q_t'(Q_ONE);
      default: return -q_t'(Q_ONE);
    endcase
  endfunction

  function automatic q_t pick_word();
    case ($urandom_range(3))
      0:       return q_t'($urandom);
      1:       return q_t'($urandom_range(131072)) - q_t'(Q_ONE);
      2:       return pick_corner();
      default: return q_t'($urandom_range(2097152)) - q_t'(1048576);
    endcase
  endfunction

  // mostly plausible transforms, the rest raw words and corners
  function automatic xform_t pick_transform();
    xform_t v;
    if ($urandom_range(99) < 70) begin
      for (int k = 0; k < 3; k++) v[k] = q_t'($urandom);
      for (int k = 3; k < 7; k++) v[k] = q_t'($urandom_range(131072)) - q_t'(Q_ONE);
      for (int k = 7; k < 10; k++) v[k] = q_t'($urandom_range(524288)) - q_t'(262144);
    end else begin
      for (int k = 0; k < 10; k++) v[k] = pick_word();
    end
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge after the transaction
  task automatic send_transform(input xform_t v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    {pos_x_i, pos_y_i, pos_z_i}             = {v[0], v[1], v[2]};
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} = {v[3], v[4], v[5], v[6]};
    {scale_x_i, scale_y_i, scale_z_i}       = {v[7], v[8], v[9]};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    xform_t v;
    q_t     one;
    q_t     half_rt2;
    int     idle_tab  [4];
    int     stall_tab [4];
    idle_tab      = '{0, 50, 0, 20};
    stall_tab     = '{0, 0, 50, 20};
    one           = q_t'(Q_ONE);
    half_rt2      = q_t'(46341);
    hold_off_reqs = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    {pos_x_i, pos_y_i, pos_z_i}              = '0;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} = '0;
    {scale_x_i, scale_y_i, scale_z_i}        = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity, quarter turns, zero and negative scale, word extremes,
    // bit patterns, floor rounding on minus one, unnormalized saturation
    send_transform('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_transform('{one, -one, 3, one, 0, 0, 0, one, one, one});
    send_transform('{0, 0, 0, half_rt2, half_rt2, 0, 0, one, one, one});
    send_transform('{0, 0, 0, half_rt2, 0, half_rt2, 0, one, 2 * one, 3 * one});
    send_transform('{0, 0, 0, half_rt2, 0, 0, half_rt2, -one, -one, -one});
    send_transform('{5, 6, 7, 0, one, 0, 0, 0, 0, 0});
    send_transform('{0, 0, 0, one, 0, 0, 0, 0, one, 0});
    send_transform('{0, 0, 0, one / 2, one / 2, one / 2, one / 2, -3 * one, one, one / 4});
    send_transform('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_transform('{1, 1, 1, 1, 1, 1, 1, 1, 1, 1});
    v = '{default: q_t'(32'h7fff_ffff)};
    send_transform(v);
    v = '{default: q_t'(32'h8000_0000)};
    send_transform(v);
    v = '{default: q_t'(32'h5555_5555)};
    send_transform(v);
    v = '{default: q_t'(32'haaaa_aaaa)};
    send_transform(v);
    send_transform('{0, 0, 0, 100 * one, 100 * one, -100 * one, 100 * one, one, -one, one});
    send_transform('{0, 0, 0, 0, 300 * one, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1});
    send_transform('{0, 0, 0, 0, 0, 0, -one, one, 32'h7fff_ffff, 32'h8000_0000});
    send_transform('{0, 0, 0, 3, -5, 7, -9, 32'h8000_0000, 32'h7fff_ffff, -1});

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      for (int n = 0; n < N_RANDOM; n++) send_transform(pick_transform());
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering back to back
        hold_off_reqs++;
        for (int n = 0; n < 40; n++) send_transform(pick_transform());
        in_valid_i = 1'b0;
        drain_results();
      end
    end
    in_valid_i = 1'b0;

    drain_results();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
